/* rtl/skl_pkg.sv */
package skl_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int TAG_WIDTH = 8;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_WIDTH-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_WIDTH-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic                 hit;
        logic                 found;
        logic [TAG_WIDTH-1:0] tag;
    } scan_t;

endpackage

/* rtl/skl_if.sv */
interface skl_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [skl_pkg::KEY_WIDTH-1:0]  entry_key;
    logic [skl_pkg::TAG_WIDTH-1:0]  entry_tag;

    modport source (output valid, func, entry_key, entry_tag, input ready);
    modport sink   (input valid, func, entry_key, entry_tag, output ready);
endinterface

interface skl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [skl_pkg::TAG_WIDTH-1:0]  found_tag;

    modport source (output valid, status, found_tag, input ready);
    modport sink   (input valid, status, found_tag, output ready);
endinterface

/* rtl/skl_cell.sv */
module skl_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  skl_pkg::cmd_t    cmd,
    input  skl_pkg::entry_t  left_entry,
    input  logic             left_gt,
    input  skl_pkg::entry_t  right_entry,
    input  skl_pkg::scan_t   scan_in,
    output skl_pkg::entry_t  entry,
    output logic             gt,
    output skl_pkg::scan_t   scan_out
);

    skl_pkg::entry_t entry_reg;
    skl_pkg::entry_t entry_next;
    logic            match;
    logic            eq;

    assign entry = entry_reg;

    always_comb
    begin
        gt    = !entry_reg.valid || ($signed(entry_reg.key) > $signed(cmd.key));
        match = entry_reg.valid && (entry_reg.tag == cmd.tag);
        eq    = entry_reg.valid && (entry_reg.key == cmd.key);

        scan_out.hit   = scan_in.hit | match;
        scan_out.found = scan_in.found | eq;
        if (scan_in.found)
        begin
            scan_out.tag = scan_in.tag;
        end
        else if (eq)
        begin
            scan_out.tag = entry_reg.tag;
        end
        else
        begin
            scan_out.tag = '0;
        end

        entry_next = entry_reg;
        if (cmd.ins && gt)
        begin
            // take the new entry at the insertion point, shift right behind it
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else
            begin
                entry_next.valid = 1'b1;
                entry_next.key   = cmd.key;
                entry_next.tag   = cmd.tag;
            end
        end
        else if (cmd.rem && (scan_in.hit || match))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

/* rtl/sorted_key_list.sv */
// Sorted key list: a row of cells kept in ascending signed key order.
// Result: registered from the accepted request transaction and held until taken.
// Throughput: one transaction per cycle unless a response is stalled; every
// cell checks the broadcast request; the first-match scan ripples along the row.
// Reset: all cells invalid (empty list), no response pending.
module sorted_key_list (
    input  logic      clk,
    input  logic      rst_n,
    skl_req_if.sink   req,
    skl_rsp_if.source rsp
);

    localparam int N = skl_pkg::CAPACITY;

    skl_pkg::entry_t  entry_w [N];
    logic             gt_w    [N];
    skl_pkg::scan_t   scan_w  [N+1];
    skl_pkg::cmd_t    cmd;
    skl_pkg::func_t   func;
    skl_pkg::status_t status_next;
    logic [skl_pkg::TAG_WIDTH-1:0] tag_next;
    logic             fire;
    logic             full;

    logic                          out_valid_reg;
    skl_pkg::status_t              status_reg;
    logic [skl_pkg::TAG_WIDTH-1:0] tag_reg;

    assign func      = skl_pkg::func_t'(req.func);
    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = entry_w[N-1].valid;
    assign scan_w[0] = '0;

    always_comb
    begin
        cmd.ins = fire && (func == skl_pkg::FUNC_INSERT) && !full;
        cmd.rem = fire && (func == skl_pkg::FUNC_REMOVE);
        cmd.key = req.entry_key;
        cmd.tag = req.entry_tag;
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            skl_pkg::entry_t left_e;
            skl_pkg::entry_t right_e;
            logic            left_g;

            if (i == 0)
            begin : g_first
                assign left_e = '0;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = entry_w[i-1];
                assign left_g = gt_w[i-1];
            end

            if (i == N-1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = entry_w[i+1];
            end

            skl_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .scan_in     (scan_w[i]),
                .entry       (entry_w[i]),
                .gt          (gt_w[i]),
                .scan_out    (scan_w[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        status_next = skl_pkg::ST_OK;
        tag_next    = '0;
        unique case (func)
            skl_pkg::FUNC_INSERT:
            begin
                status_next = full ? skl_pkg::ST_FULL : skl_pkg::ST_OK;
            end
            skl_pkg::FUNC_REMOVE:
            begin
                status_next = scan_w[N].hit ? skl_pkg::ST_OK : skl_pkg::ST_NOT_FOUND;
            end
            skl_pkg::FUNC_FIND:
            begin
                status_next = scan_w[N].found ? skl_pkg::ST_OK : skl_pkg::ST_NOT_FOUND;
                tag_next    = scan_w[N].tag;
            end
            default:
            begin
                status_next = skl_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.found_tag = tag_reg;

endmodule
